### hw/rtl/tltq_pkg.sv
// tltq_pkg: shared types, codes and sizing for the two-level task queue
// no dependencies; used by the top level by scoped names

package tltq_pkg;

    // combined capacity of both queues, also the depth of each store
    localparam int DEPTH   = 16;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int HALF_W  = 40;
    localparam int TASK_W  = 2 * HALF_W;
    localparam int LEVEL_W = 5;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        REQ_PUSH    = 2'd0,
        REQ_POP     = 2'd1,
        REQ_PROMOTE = 2'd2
    } req_e_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    typedef struct packed {
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] lo;
    } task_t;

    typedef struct packed {
        status_t            status;
        task_t              data;
        logic               served;
        logic [LEVEL_W-1:0] n_level;
        logic [LEVEL_W-1:0] p_level;
    } result_t;

    // wrap a pointer from the last entry back to zero
    function automatic ptr_t ptr_adv(input ptr_t p);
        ptr_t r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    // queue level reported modulo 32
    function automatic logic [LEVEL_W-1:0] to_level(input cnt_t c);
        logic [31:0] wide;
        wide = 32'(c);
        return wide[LEVEL_W-1:0];
    endfunction

endpackage

### hw/rtl/tltq_ram.sv
// tltq_ram: generic single-write, single-read ram with registered read data
// no dependencies

module tltq_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/two_level_task_queue_with_promotion.sv
// two_level_task_queue_with_promotion: normal and priority task fifos sharing one capacity
// depends on tltq_pkg and tltq_ram (one ram per queue)
// push, rejected and empty requests give their item in the cycle after acceptance;
// pop and promote first pass through S_READ for the registered ram read; no new request is taken there
// throughput: one request per cycle for push/reject/empty while the result slot is free or draining
// reset: rst_n asynchronous active low clears pointers, counts and handshake state; stores are not cleared

module two_level_task_queue_with_promotion (
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // task_low_bytes[39:0], task_high_bytes[79:40]
    input  logic [2:0]  s_axis_tuser,  // req_type[1:0], push_priority[2]
    // result side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,  // out_low_bytes[39:0], out_high_bytes[79:40],
                                       // normal_level[84:80], priority_level[89:85], zero[95:90]
    output logic [2:0]  m_axis_tuser   // status[1:0], served_priority[2]
);

    // ------------------------------------------------------------------
    // state registers
    // ------------------------------------------------------------------
    tltq_pkg::state_t  state_reg,      state_next;
    tltq_pkg::ptr_t    n_rd_ptr_reg,   n_rd_ptr_next;
    tltq_pkg::ptr_t    n_wr_ptr_reg,   n_wr_ptr_next;
    tltq_pkg::ptr_t    p_rd_ptr_reg,   p_rd_ptr_next;
    tltq_pkg::ptr_t    p_wr_ptr_reg,   p_wr_ptr_next;
    tltq_pkg::cnt_t    n_count_reg,    n_count_next;
    tltq_pkg::cnt_t    p_count_reg,    p_count_next;
    tltq_pkg::cnt_t    occ_reg,        occ_next;
    logic              pend_pri_reg,   pend_pri_next;   // pop in flight serves the priority queue
    logic              pend_prom_reg,  pend_prom_next;  // promote in flight
    logic              out_valid_reg,  out_valid_next;
    tltq_pkg::result_t out_reg,        out_next;

    // ------------------------------------------------------------------
    // store rams
    // ------------------------------------------------------------------
    logic            n_we;
    logic            p_we;
    tltq_pkg::task_t p_wdata;
    tltq_pkg::task_t n_rdata;
    tltq_pkg::task_t p_rdata;
    tltq_pkg::task_t in_task;

    // both rams read their head every cycle; the head pointer only moves when
    // a pop or promote is accepted, so the data is ready in the following cycle
    tltq_ram #(
        .WIDTH (tltq_pkg::TASK_W),
        .DEPTH (tltq_pkg::DEPTH)
    ) u_normal_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_wr_ptr_reg),
        .wdata (in_task),
        .raddr (n_rd_ptr_reg),
        .rdata (n_rdata)
    );

    tltq_ram #(
        .WIDTH (tltq_pkg::TASK_W),
        .DEPTH (tltq_pkg::DEPTH)
    ) u_priority_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_wr_ptr_reg),
        .wdata (p_wdata),
        .raddr (p_rd_ptr_reg),
        .rdata (p_rdata)
    );

    // ------------------------------------------------------------------
    // input decode
    // ------------------------------------------------------------------
    tltq_pkg::req_e_t req;
    logic             push_pri;
    logic             in_acc;
    logic             out_load;

    assign req      = tltq_pkg::req_e_t'(s_axis_tuser[1:0]);
    assign push_pri = s_axis_tuser[2];
    assign in_task  = tltq_pkg::task_t'(s_axis_tdata);

    // a new item is taken only between operations and when the result slot is free or draining
    assign s_axis_tready = (state_reg == tltq_pkg::S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // next state and store control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        n_rd_ptr_next  = n_rd_ptr_reg;
        n_wr_ptr_next  = n_wr_ptr_reg;
        p_rd_ptr_next  = p_rd_ptr_reg;
        p_wr_ptr_next  = p_wr_ptr_reg;
        n_count_next   = n_count_reg;
        p_count_next   = p_count_reg;
        occ_next       = occ_reg;
        pend_pri_next  = pend_pri_reg;
        pend_prom_next = pend_prom_reg;
        out_next       = out_reg;
        out_load       = 1'b0;
        n_we           = 1'b0;
        p_we           = 1'b0;
        p_wdata        = in_task;

        unique case (state_reg)
            tltq_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    out_next.status = tltq_pkg::ST_DONE;
                    out_next.data   = '0;
                    out_next.served = 1'b0;
                    unique case (req)
                        tltq_pkg::REQ_PUSH:
                        begin
                            out_load = 1'b1;
                            if (occ_reg >= tltq_pkg::CNT_W'(tltq_pkg::DEPTH))
                            begin
                                out_next.status = tltq_pkg::ST_FULL;
                            end
                            else if (push_pri)
                            begin
                                p_we          = 1'b1;
                                p_wr_ptr_next = tltq_pkg::ptr_adv(p_wr_ptr_reg);
                                p_count_next  = p_count_reg + tltq_pkg::CNT_W'(1);
                                occ_next      = occ_reg + tltq_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                n_we          = 1'b1;
                                n_wr_ptr_next = tltq_pkg::ptr_adv(n_wr_ptr_reg);
                                n_count_next  = n_count_reg + tltq_pkg::CNT_W'(1);
                                occ_next      = occ_reg + tltq_pkg::CNT_W'(1);
                            end
                        end
                        tltq_pkg::REQ_POP:
                        begin
                            if (p_count_reg != '0)
                            begin
                                p_rd_ptr_next  = tltq_pkg::ptr_adv(p_rd_ptr_reg);
                                p_count_next   = p_count_reg - tltq_pkg::CNT_W'(1);
                                occ_next       = occ_reg - tltq_pkg::CNT_W'(1);
                                pend_pri_next  = 1'b1;
                                pend_prom_next = 1'b0;
                                state_next     = tltq_pkg::S_READ;
                            end
                            else if (n_count_reg != '0)
                            begin
                                n_rd_ptr_next  = tltq_pkg::ptr_adv(n_rd_ptr_reg);
                                n_count_next   = n_count_reg - tltq_pkg::CNT_W'(1);
                                occ_next       = occ_reg - tltq_pkg::CNT_W'(1);
                                pend_pri_next  = 1'b0;
                                pend_prom_next = 1'b0;
                                state_next     = tltq_pkg::S_READ;
                            end
                            else
                            begin
                                out_next.status = tltq_pkg::ST_EMPTY;
                                out_load        = 1'b1;
                            end
                        end
                        tltq_pkg::REQ_PROMOTE:
                        begin
                            // counts move now, the priority write follows with the read data
                            if (n_count_reg != '0)
                            begin
                                n_rd_ptr_next  = tltq_pkg::ptr_adv(n_rd_ptr_reg);
                                n_count_next   = n_count_reg - tltq_pkg::CNT_W'(1);
                                p_count_next   = p_count_reg + tltq_pkg::CNT_W'(1);
                                pend_pri_next  = 1'b0;
                                pend_prom_next = 1'b1;
                                state_next     = tltq_pkg::S_READ;
                            end
                            else
                            begin
                                out_next.status = tltq_pkg::ST_EMPTY;
                                out_load        = 1'b1;
                            end
                        end
                        default:
                        begin
                            // unused request code
                            out_next.status = tltq_pkg::ST_EMPTY;
                            out_load        = 1'b1;
                        end
                    endcase
                end
            end
            tltq_pkg::S_READ:
            begin
                state_next      = tltq_pkg::S_IDLE;
                out_load        = 1'b1;
                out_next.status = tltq_pkg::ST_DONE;
                if (pend_prom_reg)
                begin
                    // normal head lands at the priority tail
                    p_we            = 1'b1;
                    p_wdata         = n_rdata;
                    p_wr_ptr_next   = tltq_pkg::ptr_adv(p_wr_ptr_reg);
                    out_next.data   = '0;
                    out_next.served = 1'b0;
                end
                else
                begin
                    out_next.data   = pend_pri_reg ? p_rdata : n_rdata;
                    out_next.served = pend_pri_reg;
                end
            end
            default:
            begin
                state_next = tltq_pkg::S_IDLE;
            end
        endcase

        // levels after the request
        if (out_load)
        begin
            out_next.n_level = tltq_pkg::to_level(n_count_next);
            out_next.p_level = tltq_pkg::to_level(p_count_next);
        end

        out_valid_next = out_load || (out_valid_reg && !m_axis_tready);
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tltq_pkg::S_IDLE;
            n_rd_ptr_reg  <= '0;
            n_wr_ptr_reg  <= '0;
            p_rd_ptr_reg  <= '0;
            p_wr_ptr_reg  <= '0;
            n_count_reg   <= '0;
            p_count_reg   <= '0;
            occ_reg       <= '0;
            pend_pri_reg  <= 1'b0;
            pend_prom_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_rd_ptr_reg  <= n_rd_ptr_next;
            n_wr_ptr_reg  <= n_wr_ptr_next;
            p_rd_ptr_reg  <= p_rd_ptr_next;
            p_wr_ptr_reg  <= p_wr_ptr_next;
            n_count_reg   <= n_count_next;
            p_count_reg   <= p_count_next;
            occ_reg       <= occ_next;
            pend_pri_reg  <= pend_pri_next;
            pend_prom_reg <= pend_prom_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // ------------------------------------------------------------------
    // result port
    // ------------------------------------------------------------------
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_reg.p_level, out_reg.n_level, out_reg.data};
    assign m_axis_tuser  = {out_reg.served, out_reg.status};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    // shared occupancy always equals the sum of the two queue counts
    a_occ_sum: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, occ_reg} == ({1'b0, n_count_reg} + {1'b0, p_count_reg}))
        else $error("occupancy does not match queue counts");

    // combined occupancy never exceeds the capacity
    a_occ_cap: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= tltq_pkg::CNT_W'(tltq_pkg::DEPTH))
        else $error("occupancy beyond capacity");

    // the result slot is free while a store read is in flight
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tltq_pkg::S_READ) |-> !out_valid_reg)
        else $error("result slot busy during store read");

    // a store read always produces a result on the next cycle
    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tltq_pkg::S_READ) |=> (out_valid_reg && state_reg == tltq_pkg::S_IDLE))
        else $error("pop or promote result missing");
`endif

endmodule

### dv/tltq_result_checker.sv
// tltq_result_checker: watches both streams of the two-level task queue, predicts each result
// and compares it field by field; depends on tltq_pkg for sizes, codes and the task type

module tltq_result_checker
    import tltq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // task_low_bytes[39:0], task_high_bytes[79:40]
    input  logic [2:0]  s_axis_tuser,  // req_type[1:0], push_priority[2]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [95:0] m_axis_tdata,  // out_low_bytes[39:0], out_high_bytes[79:40],
                                       // normal_level[84:80], priority_level[89:85], zero[95:90]
    input  logic [2:0]  m_axis_tuser,  // status[1:0], served_priority[2]
    output int          errors,
    output int          pending,
    output int          results_checked,
    output int          full_rejects
);

    localparam int MAX_PRINTED = 40;

    typedef struct {
        status_t      status;
        logic [39:0]  lo;
        logic [39:0]  hi;
        logic         served;
        logic [4:0]   n_level;
        logic [4:0]   p_level;
    } outcome_t;

    // shadow copy of both fifos
    task_t normal_fifo [DEPTH];
    task_t urgent_fifo [DEPTH];
    int    n_rd, n_wr, n_cnt;
    int    p_rd, p_wr, p_cnt;
    int    occupancy;

    outcome_t awaited_q [$];

    function automatic int next_slot(input int p);
        return (p == DEPTH - 1) ? 0 : p + 1;
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    // one request against the shadow state
    task automatic apply_request(input logic [1:0] req, input logic pri, input task_t job,
                                 output outcome_t o);
        task_t head;
        o.status = ST_DONE;
        o.lo     = '0;
        o.hi     = '0;
        o.served = 1'b0;
        case (req)
            REQ_PUSH:
            begin
                if (occupancy >= DEPTH)
                    o.status = ST_FULL;
                else if (pri)
                begin
                    urgent_fifo[p_wr] = job;
                    p_wr = next_slot(p_wr);
                    p_cnt++;
                    occupancy++;
                end
                else
                begin
                    normal_fifo[n_wr] = job;
                    n_wr = next_slot(n_wr);
                    n_cnt++;
                    occupancy++;
                end
            end
            REQ_POP:
            begin
                if (p_cnt > 0)
                begin
                    head = urgent_fifo[p_rd];
                    p_rd = next_slot(p_rd);
                    p_cnt--;
                    occupancy--;
                    o.lo     = head.lo;
                    o.hi     = head.hi;
                    o.served = 1'b1;
                end
                else if (n_cnt > 0)
                begin
                    head = normal_fifo[n_rd];
                    n_rd = next_slot(n_rd);
                    n_cnt--;
                    occupancy--;
                    o.lo = head.lo;
                    o.hi = head.hi;
                end
                else
                    o.status = ST_EMPTY;
            end
            REQ_PROMOTE:
            begin
                if (n_cnt > 0)
                begin
                    head = normal_fifo[n_rd];
                    n_rd = next_slot(n_rd);
                    n_cnt--;
                    urgent_fifo[p_wr] = head;
                    p_wr = next_slot(p_wr);
                    p_cnt++;
                end
                else
                    o.status = ST_EMPTY;
            end
            default:
                o.status = ST_EMPTY;
        endcase
        o.n_level = 5'(n_cnt);
        o.p_level = 5'(p_cnt);
    endtask

    task automatic compare_result(input outcome_t o);
        if (m_axis_tuser[1:0] !== o.status)
            report_mismatch($sformatf("status expected %0d got %0d", o.status, m_axis_tuser[1:0]));
        if (m_axis_tdata[39:0] !== o.lo)
            report_mismatch($sformatf("low bytes expected %h got %h", o.lo, m_axis_tdata[39:0]));
        if (m_axis_tdata[79:40] !== o.hi)
            report_mismatch($sformatf("high bytes expected %h got %h", o.hi, m_axis_tdata[79:40]));
        if (m_axis_tuser[2] !== o.served)
            report_mismatch($sformatf("served flag expected %b got %b", o.served, m_axis_tuser[2]));
        if (m_axis_tdata[84:80] !== o.n_level)
            report_mismatch($sformatf("normal level expected %0d got %0d",
                                      o.n_level, m_axis_tdata[84:80]));
        if (m_axis_tdata[89:85] !== o.p_level)
            report_mismatch($sformatf("priority level expected %0d got %0d",
                                      o.p_level, m_axis_tdata[89:85]));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t o;
        task_t    job;
        if (!rst_n)
        begin
            n_rd            = 0;
            n_wr            = 0;
            n_cnt           = 0;
            p_rd            = 0;
            p_wr            = 0;
            p_cnt           = 0;
            occupancy       = 0;
            awaited_q.delete();
            errors          = 0;
            pending         = 0;
            results_checked = 0;
            full_rejects    = 0;
        end
        else
        begin
            // results first: an item accepted at this edge cannot have its result yet
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_q.size() == 0)
                    report_mismatch($sformatf("result with nothing awaited, tuser %h tdata %h",
                                              m_axis_tuser, m_axis_tdata));
                else
                begin
                    o = awaited_q.pop_front();
                    compare_result(o);
                    results_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                job.lo = s_axis_tdata[39:0];
                job.hi = s_axis_tdata[79:40];
                apply_request(s_axis_tuser[1:0], s_axis_tuser[2], job, o);
                if (o.status == ST_FULL)
                    full_rejects++;
                awaited_q.push_back(o);
            end
            pending = awaited_q.size();
        end
    end

endmodule

### dv/tb_two_level_task_queue_with_promotion.sv
// tb_two_level_task_queue_with_promotion: stimulus and verdict for the two-level task queue
// depends on tltq_pkg, the block itself and tltq_result_checker

module tb_two_level_task_queue_with_promotion;

    import tltq_pkg::*;

    // request code the block answers with an empty status
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1700;
    localparam int RUN_LIMIT    = 300000;
    // pop and promote results pass through the store read state, which this margin covers
    localparam int SETTLE       = 8;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;
    localparam int MODE_AGING = 3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;   // task_low_bytes[39:0], task_high_bytes[79:40]
    logic [2:0]  s_axis_tuser = '0;   // req_type[1:0], push_priority[2]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;        // out_low_bytes[39:0], out_high_bytes[79:40],
                                      // normal_level[84:80], priority_level[89:85]
    logic [2:0]  m_axis_tuser;        // status[1:0], served_priority[2]

    int errors;
    int pending;
    int results_checked;
    int full_rejects;

    // sender burst state
    int burst_left = 0;

    // receiver pattern state
    int rx_cycle = 0;
    int rx_mode  = 0;

    int cycles = 0;

    int sent_push    = 0;
    int sent_pop     = 0;
    int sent_promote = 0;
    int sent_unused  = 0;

    always #5 clk = ~clk;

    two_level_task_queue_with_promotion u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    tltq_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .errors          (errors),
        .pending         (pending),
        .results_checked (results_checked),
        .full_rejects    (full_rejects)
    );

    // receiver back-pressure: the pattern is redrawn at random from four kinds:
    // always ready, coin toss, long stalls, or a fixed one-in-four stall
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 256 == 0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= (rx_cycle % 4 != 3);
        endcase
    end

    // watchdog
    initial
    begin
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still awaited", cycles, pending);
        $display("*** FAILED ***");
        $finish;
    end

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_request(input logic [1:0] req, input logic pri,
                                input logic [39:0] lo, input logic [39:0] hi);
        int gap;
        if (burst_left == 0)
        begin
            // roughly a third of the bursts follow the last one without a gap
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {pri, req};
        s_axis_tdata  <= {hi, lo};
        case (req)
            REQ_PUSH:    sent_push++;
            REQ_POP:     sent_pop++;
            REQ_PROMOTE: sent_promote++;
            default:     sent_unused++;
        endcase
        // ready is settled by the falling edge, so the handshake is known ahead of the edge
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [39:0] random_half();
        logic [63:0] raw;
        int          pick;
        raw  = {$urandom(), $urandom()};
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return raw[39:0];
    endfunction

    // request kind drawn from the bias of the current phase
    function automatic logic [1:0] pick_request(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
                return (r < 75) ? REQ_PUSH : (r < 85) ? REQ_POP :
                       (r < 96) ? REQ_PROMOTE : REQ_UNUSED;
            MODE_DRAIN:
                return (r < 20) ? REQ_PUSH : (r < 85) ? REQ_POP :
                       (r < 96) ? REQ_PROMOTE : REQ_UNUSED;
            MODE_AGING:
                return (r < 50) ? REQ_PUSH : (r < 68) ? REQ_POP :
                       (r < 97) ? REQ_PROMOTE : REQ_UNUSED;
            default:
                return (r < 40) ? REQ_PUSH : (r < 75) ? REQ_POP :
                       (r < 97) ? REQ_PROMOTE : REQ_UNUSED;
        endcase
    endfunction

    initial
    begin
        int         done_items;
        int         phase_left;
        int         mode;
        logic [1:0] req;
        logic       pri;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening: extremes of the data, both queues, every empty case
        send_request(REQ_PUSH,    1'b0, '1, '1);
        send_request(REQ_PUSH,    1'b1, '0, '0);
        send_request(REQ_POP,     1'b0, random_half(), random_half()); // priority served first
        send_request(REQ_POP,     1'b1, random_half(), random_half()); // then the normal one
        send_request(REQ_POP,     1'b0, '1, '1);                       // both queues empty
        send_request(REQ_PROMOTE, 1'b1, '1, '1);                       // nothing to promote
        send_request(REQ_UNUSED,  1'b1, '1, '1);                       // unused code, answered as empty
        send_request(REQ_UNUSED,  1'b0, '0, '0);
        send_request(REQ_PUSH,    1'b0, 40'hAA_AAAA_AAAA, 40'h55_5555_5555);
        send_request(REQ_PUSH,    1'b1, 40'h55_5555_5555, 40'hAA_AAAA_AAAA);
        send_request(REQ_PROMOTE, 1'b0, random_half(), random_half()); // normal head ages up
        send_request(REQ_POP,     1'b0, '0, '0);                       // original priority task
        send_request(REQ_POP,     1'b0, '0, '0);                       // promoted task
        send_request(REQ_PUSH,    1'b0, 40'h01_2345_6789, 40'h98_7654_3210);
        send_request(REQ_PUSH,    1'b0, 40'hFE_DCBA_9876, 40'h00_0000_0001);
        send_request(REQ_PROMOTE, 1'b1, '0, '0);
        send_request(REQ_POP,     1'b1, '1, '1);
        send_request(REQ_POP,     1'b1, '1, '1);

        // random phases, each leaning towards filling, draining, mixing or aging
        done_items = 0;
        phase_left = 0;
        mode       = MODE_MIXED;
        while (done_items < RANDOM_ITEMS)
        begin
            if (phase_left == 0)
            begin
                mode       = $urandom_range(MODE_FILL, MODE_AGING);
                phase_left = $urandom_range(10, 60);
            end
            req = pick_request(mode);
            // aging phases load the normal queue so promotes have work to do
            pri = (mode == MODE_AGING && req == REQ_PUSH) ? ($urandom_range(0, 9) == 0)
                                                          : 1'($urandom_range(0, 1));
            send_request(req, pri, random_half(), random_half());
            phase_left--;
            done_items++;
        end
        s_axis_tvalid <= 1'b0;

        // sample the awaited count away from the rising edge, once the last item is booked
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("requests sent: %0d push, %0d pop, %0d promote, %0d with the unused code",
                 sent_push, sent_pop, sent_promote, sent_unused);
        $display("results compared: %0d, pushes turned away as full: %0d, mismatches: %0d",
                 results_checked, full_rejects, errors);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
